// ===== rtl/assert_macros.svh =====
// assertion helpers, sampled on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define GXPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gxpc: assertion failed");

`define GXPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gxpc: implication failed");

`define GXPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gxpc: next-cycle check failed");

`endif

// ===== rtl/gxpc_pkg.sv =====
package gxpc_pkg;

  localparam int CELL_W   = 4;
  localparam int COUNT_W  = 30;
  localparam int SIZE_W   = 10;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  localparam int MAX_COLS_DEF   = 512;
  localparam int MAX_ROWS_DEF   = 512;
  localparam int XOR_STATES_DEF = 16;

  localparam logic [COUNT_W:0] PATH_MOD = (COUNT_W + 1)'(1000000007);

  typedef enum logic [1:0] {
    REG_NUM_ROWS   = 2'd0,
    REG_NUM_COLS   = 2'd1,
    REG_TARGET_XOR = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic en;
    logic first;
    logic use_above;
    logic use_left;
  } lane_ctrl_t;

endpackage

// ===== rtl/gxpc_cell_if.sv =====
interface gxpc_cell_if;
  import gxpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

// ===== rtl/gxpc_count_if.sv =====
interface gxpc_count_if;
  import gxpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] path_count;

  modport source (output valid, output path_count, input ready);
  modport sink   (input valid, input path_count, output ready);
endinterface

// ===== rtl/gxpc_row_mem.sv =====
module gxpc_row_mem #(
  parameter int DEPTH = gxpc_pkg::MAX_COLS_DEF,
  parameter int WIDTH = gxpc_pkg::COUNT_W * gxpc_pkg::XOR_STATES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gxpc_lane.sv =====
module gxpc_lane #(
  parameter int LANE       = 0,
  parameter int XOR_STATES = gxpc_pkg::XOR_STATES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gxpc_pkg::lane_ctrl_t        ctrl_i,
  input  logic [gxpc_pkg::CELL_W-1:0] cell_value_i,
  input  logic [gxpc_pkg::COUNT_W-1:0] above_i [XOR_STATES],
  input  logic [gxpc_pkg::COUNT_W-1:0] left_i  [XOR_STATES],
  output logic [gxpc_pkg::COUNT_W-1:0] fresh_o,
  output logic [gxpc_pkg::COUNT_W-1:0] count_o
);
  import gxpc_pkg::*;

  localparam int XW = $clog2(XOR_STATES);
  localparam int VW = (XW > CELL_W) ? XW : CELL_W;

  logic [VW-1:0]      src;
  logic               src_ok;
  logic [XW-1:0]      idx;
  logic [COUNT_W-1:0] a;
  logic [COUNT_W-1:0] b;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W:0]   red;
  logic [COUNT_W-1:0] fresh_d;
  logic [COUNT_W-1:0] count_q;

  // path xor of this lane comes from the lane at our index xor the cell value
  assign src    = VW'(LANE) ^ VW'(cell_value_i);
  assign src_ok = {1'b0, src} < (VW + 1)'(XOR_STATES);
  assign idx    = src[XW-1:0];

  always_comb begin
    a   = ctrl_i.use_above ? above_i[idx] : '0;
    b   = ctrl_i.use_left  ? left_i[idx]  : '0;
    sum = {1'b0, a} + {1'b0, b};
    red = (sum >= PATH_MOD) ? sum - PATH_MOD : sum;
    if (ctrl_i.first) begin
      fresh_d = (VW'(LANE) == VW'(cell_value_i)) ? COUNT_W'(1) : '0;
    end else if (src_ok) begin
      fresh_d = red[COUNT_W-1:0];
    end else begin
      fresh_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.en) begin
      count_q <= fresh_d;
    end
  end

  assign fresh_o = fresh_d;
  assign count_o = count_q;

endmodule

// ===== rtl/grid_xor_path_counter.sv =====
// channel   | dir | handshake     | payload
// cell_i    | in  | valid / ready | cell_value [3:0]
// count_o   | out | valid / ready | path_count [29:0]
// apb       | in  | psel/penable  | num_rows, num_cols, target_xor at 0x0, 0x4, 0x8
//
// one cell per cycle unless stalled as below; the lane stage registers accepted cells
// and updates lane and result registers; each lane's modular add closes the left-cell
// loop; the row store is read ahead and same-column writes come from lane registers
// the input stalls only while the grid's last cell waits for a free output register
// reset is asynchronous; the row store is not cleared and is written before it is read
`include "assert_macros.svh"

module grid_xor_path_counter #(
  parameter int MAX_COLS   = gxpc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = gxpc_pkg::MAX_ROWS_DEF,
  parameter int XOR_STATES = gxpc_pkg::XOR_STATES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gxpc_cell_if.sink                   cell_i,
  gxpc_count_if.source                count_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gxpc_pkg::CFG_AW-1:0] paddr,
  input  logic [gxpc_pkg::CFG_DW-1:0] pwdata,
  output logic [gxpc_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import gxpc_pkg::*;

  localparam int AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int XW   = $clog2(XOR_STATES);
  localparam int VW   = (XW > CELL_W) ? XW : CELL_W;
  localparam int CW0  = ($clog2(MAX_ROWS + 1) > $clog2(MAX_COLS + 1)) ?
                        $clog2(MAX_ROWS + 1) : $clog2(MAX_COLS + 1);
  localparam int CMPW = ((CW0 > SIZE_W) ? CW0 : SIZE_W) + 1;
  localparam int MW   = COUNT_W * XOR_STATES;

  // configuration
  logic [SIZE_W-1:0] num_rows_q, num_rows_d;
  logic [SIZE_W-1:0] num_cols_q, num_cols_d;
  logic [CELL_W-1:0] target_q, target_d;
  logic              cfg_wr;
  cfg_reg_e          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);

  always_comb begin
    num_rows_d = num_rows_q;
    num_cols_d = num_cols_q;
    target_d   = target_q;
    prdata     = '0;
    case (cfg_sel)
      REG_NUM_ROWS: begin
        prdata = CFG_DW'(num_rows_q);
        if (cfg_wr) num_rows_d = pwdata[SIZE_W-1:0];
      end
      REG_NUM_COLS: begin
        prdata = CFG_DW'(num_cols_q);
        if (cfg_wr) num_cols_d = pwdata[SIZE_W-1:0];
      end
      REG_TARGET_XOR: begin
        prdata = CFG_DW'(target_q);
        if (cfg_wr) target_d = pwdata[CELL_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= SIZE_W'(1);
      num_cols_q <= SIZE_W'(1);
      target_q   <= '0;
    end else begin
      num_rows_q <= num_rows_d;
      num_cols_q <= num_cols_d;
      target_q   <= target_d;
    end
  end

  // effective grid size
  logic [CMPW-1:0] rows_eff;
  logic [CMPW-1:0] cols_eff;

  always_comb begin
    if (num_rows_q == '0) begin
      rows_eff = CMPW'(1);
    end else if (CMPW'(num_rows_q) > CMPW'(MAX_ROWS)) begin
      rows_eff = CMPW'(MAX_ROWS);
    end else begin
      rows_eff = CMPW'(num_rows_q);
    end
    if (num_cols_q == '0) begin
      cols_eff = CMPW'(1);
    end else if (CMPW'(num_cols_q) > CMPW'(MAX_COLS)) begin
      cols_eff = CMPW'(MAX_COLS);
    end else begin
      cols_eff = CMPW'(num_cols_q);
    end
  end

  // position and issue stage
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          accept;
  logic          col_last;
  logic          row_last;

  // lane stage
  logic              s1_valid_q, s1_valid_d;
  logic              s1_adv;
  logic [AW-1:0]     s1_col_q;
  logic [CELL_W-1:0] s1_value_q;
  logic              s1_first_q;
  logic              s1_use_above_q;
  logic              s1_use_left_q;
  logic              s1_last_q;
  logic              s1_bypass_q;
  logic              out_free;

  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;

  assign out_free     = !out_valid_q || count_o.ready;
  assign s1_adv       = s1_valid_q && (!s1_last_q || out_free);
  assign cell_i.ready = !s1_valid_q || s1_adv;
  assign accept       = cell_i.valid && cell_i.ready;

  assign col_last = (CMPW'(col_q) + CMPW'(1)) >= cols_eff;
  assign row_last = (CMPW'(row_q) + CMPW'(1)) >= rows_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  assign s1_valid_d = accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q       <= col_q;
      s1_value_q     <= cell_i.cell_value;
      s1_first_q     <= (row_q == '0) && (col_q == '0);
      s1_use_above_q <= row_q != '0;
      s1_use_left_q  <= col_q != '0;
      s1_last_q      <= col_last && row_last;
      s1_bypass_q    <= s1_adv && (s1_col_q == col_q);
    end
  end

  // row store
  logic [MW-1:0]      wdata;
  logic [MW-1:0]      rdata;
  logic [COUNT_W-1:0] fresh [XOR_STATES];
  logic [COUNT_W-1:0] lane_count [XOR_STATES];
  logic [COUNT_W-1:0] above [XOR_STATES];
  lane_ctrl_t         lane_ctrl;

  gxpc_row_mem #(
    .DEPTH (MAX_COLS),
    .WIDTH (MW),
    .AW    (AW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  always_comb begin
    lane_ctrl.en        = s1_adv;
    lane_ctrl.first     = s1_first_q;
    lane_ctrl.use_above = s1_use_above_q;
    lane_ctrl.use_left  = s1_use_left_q;
  end

  for (genvar g = 0; g < XOR_STATES; g++) begin : g_lane
    assign wdata[g*COUNT_W +: COUNT_W] = fresh[g];
    assign above[g] = s1_bypass_q ? lane_count[g] : rdata[g*COUNT_W +: COUNT_W];

    gxpc_lane #(
      .LANE       (g),
      .XOR_STATES (XOR_STATES)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (lane_ctrl),
      .cell_value_i (s1_value_q),
      .above_i      (above),
      .left_i       (lane_count),
      .fresh_o      (fresh[g]),
      .count_o      (lane_count[g])
    );
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !count_o.ready;
    out_count_d = out_count_q;
    if (s1_adv && s1_last_q) begin
      out_valid_d = 1'b1;
      if ({1'b0, VW'(target_q)} < (VW + 1)'(XOR_STATES)) begin
        out_count_d = fresh[XW'(target_q)];
      end else begin
        out_count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
  end

  assign count_o.valid      = out_valid_q;
  assign count_o.path_count = out_count_q;

  `GXPC_ASSERT_IMP(a_count_reduced, count_o.valid, {1'b0, count_o.path_count} < PATH_MOD)
  `GXPC_ASSERT_NEXT(a_stall_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_col_q))
  `GXPC_ASSERT_IMP(a_bypass_single_col, s1_valid_q && s1_bypass_q, s1_col_q == '0)
  `GXPC_ASSERT_IMP(a_stall_cause, !cell_i.ready, s1_valid_q && s1_last_q && out_valid_q)

endmodule
